// ===== rtl/abd_pkg.sv =====
// Package for the ambient backlight dimmer: sizes, codes, the queued item type
// and the duty saturation helper. No dependencies.
package abd_pkg;

    localparam int NUM_LEVELS = 8;
    localparam int DAY_LEVELS = 4;
    localparam int LEVEL_W    = $clog2(NUM_LEVELS);
    localparam int DUTY_W     = 7;
    localparam int LUX_W      = 16;

    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_RESET    = 7'd50;
    localparam logic [DUTY_W-1:0] SLEW_RESET    = 7'd1;
    localparam logic [LUX_W-1:0]  INVALID_RESET = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP    = LEVEL_W'(NUM_LEVELS - 1);

    // configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_DUTY = 2'd0;
    localparam logic [1:0] CFG_SLEW_STEP    = 2'd1;
    localparam logic [1:0] CFG_INVALID_LUX  = 2'd2;

    // input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_TABLE = 1'b1;

    // item kinds after classification
    localparam logic [1:0] KIND_HOLD  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // table columns
    localparam logic [2:0] COL_THRESH = 3'd0;
    localparam logic [2:0] COL_LOW    = 3'd1;
    localparam logic [2:0] COL_MED    = 3'd2;
    localparam logic [2:0] COL_HIGH   = 3'd3;
    localparam logic [2:0] COL_AUTO   = 3'd4;

    // brightness choices
    localparam logic [1:0] CHOICE_AUTO = 2'd0;
    localparam logic [1:0] CHOICE_LOW  = 2'd1;
    localparam logic [1:0] CHOICE_MED  = 2'd2;
    localparam logic [1:0] CHOICE_HIGH = 2'd3;

    // ambient modes
    localparam logic [1:0] MODE_DAY   = 2'd0;
    localparam logic [1:0] MODE_NIGHT = 2'd1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic [LUX_W-1:0]   lux;
        logic [1:0]         mode;
        logic [1:0]         choice;
        logic               welcome;
        logic [LEVEL_W-1:0] row;
        logic [2:0]         col;
        logic [LUX_W-1:0]   value;
    } item_t;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [LUX_W-1:0] v);
        logic [DUTY_W-1:0] r;
        begin
            r = (v > LUX_W'(DUTY_MAX)) ? DUTY_MAX : v[DUTY_W-1:0];
            return r;
        end
    endfunction

endpackage

// ===== rtl/abd_front.sv =====
// Front end: classifies an incoming item into hold, tick or table write and
// saturates table duties. Depends on abd_pkg.
module abd_front (
    input  logic                      opcode,
    input  logic [abd_pkg::LUX_W-1:0] lux,
    input  logic [1:0]                ambient_mode,
    input  logic [1:0]                brightness_choice,
    input  logic                      ignition_on,
    input  logic                      low_voltage_ok,
    input  logic                      high_voltage_ok,
    input  logic                      welcome_done,
    input  logic [2:0]                table_level,
    input  logic [2:0]                table_column,
    input  logic [abd_pkg::LUX_W-1:0] table_value,
    output abd_pkg::item_t            item
);

    logic row_ok;
    logic col_ok;
    logic power_ok;

    always_comb
    begin
        row_ok   = (32'(table_level) < abd_pkg::NUM_LEVELS);
        col_ok   = (table_column <= abd_pkg::COL_AUTO);
        power_ok = ignition_on & low_voltage_ok & high_voltage_ok;

        item.lux     = lux;
        item.mode    = ambient_mode;
        item.choice  = brightness_choice;
        item.welcome = welcome_done;
        item.row     = table_level[abd_pkg::LEVEL_W-1:0];
        item.col     = table_column;
        if (table_column == abd_pkg::COL_THRESH)
        begin
            item.value = table_value;
        end
        else
        begin
            item.value = abd_pkg::LUX_W'(abd_pkg::sat_duty(table_value));
        end

        if (opcode == abd_pkg::OP_TABLE)
        begin
            item.kind = (row_ok && col_ok) ? abd_pkg::KIND_WRITE : abd_pkg::KIND_HOLD;
        end
        else
        begin
            item.kind = power_ok ? abd_pkg::KIND_TICK : abd_pkg::KIND_HOLD;
        end
    end

endmodule

// ===== rtl/abd_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on abd_pkg for the item type and depth.
module abd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  abd_pkg::item_t push_item,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output abd_pkg::item_t head
);

    abd_pkg::item_t                   mem [abd_pkg::FIFO_DEPTH];
    logic [abd_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [abd_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [abd_pkg::FIFO_CNT_W-1:0]   count_reg;
    logic [abd_pkg::FIFO_CNT_W-1:0]   count_next;
    logic                             do_push;
    logic                             do_pop;

    assign not_full  = (count_reg != abd_pkg::FIFO_CNT_W'(abd_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & not_full;
    assign do_pop    = pop & not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == abd_pkg::FIFO_DEPTH - 1)
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == abd_pkg::FIFO_DEPTH - 1)
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/abd_back.sv =====
// Back end: configuration registers, level table, level/target/duty state,
// slew step and the output register. Depends on abd_pkg.
module abd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [abd_pkg::LUX_W-1:0]   cfg_data,
    input  logic                        head_valid,
    input  abd_pkg::item_t              head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [abd_pkg::DUTY_W-1:0]  duty_out,
    output logic                        pwm_update,
    output logic [abd_pkg::DUTY_W-1:0]  target_duty,
    output logic [2:0]                  light_level
);

    logic [abd_pkg::DUTY_W-1:0]  default_duty_reg;
    logic [abd_pkg::DUTY_W-1:0]  slew_step_reg;
    logic [abd_pkg::LUX_W-1:0]   invalid_lux_reg;

    logic [abd_pkg::LUX_W-1:0]   thresh_reg [abd_pkg::NUM_LEVELS];
    logic [abd_pkg::DUTY_W-1:0]  low_reg    [abd_pkg::NUM_LEVELS];
    logic [abd_pkg::DUTY_W-1:0]  med_reg    [abd_pkg::NUM_LEVELS];
    logic [abd_pkg::DUTY_W-1:0]  high_reg   [abd_pkg::NUM_LEVELS];
    logic [abd_pkg::DUTY_W-1:0]  auto_reg   [abd_pkg::NUM_LEVELS];

    logic [abd_pkg::DUTY_W-1:0]  target_reg;
    logic [abd_pkg::DUTY_W-1:0]  target_next;
    logic [abd_pkg::DUTY_W-1:0]  duty_reg;
    logic [abd_pkg::DUTY_W-1:0]  duty_next;
    logic [abd_pkg::LEVEL_W-1:0] level_reg;
    logic [abd_pkg::LEVEL_W-1:0] level_next;
    logic                        pending_reg;
    logic                        pending_next;
    logic                        pulse;

    logic                        out_valid_reg;
    logic [abd_pkg::DUTY_W-1:0]  duty_out_reg;
    logic                        pwm_update_reg;
    logic [abd_pkg::DUTY_W-1:0]  target_out_reg;
    logic [abd_pkg::LEVEL_W-1:0] level_out_reg;

    logic                        day_hit;
    logic [abd_pkg::LEVEL_W-1:0] day_idx;
    logic                        night_hit;
    logic [abd_pkg::LEVEL_W-1:0] night_idx;
    logic                        pick;
    logic [abd_pkg::DUTY_W-1:0]  picked;
    logic [abd_pkg::DUTY_W-1:0]  slew;
    logic [abd_pkg::DUTY_W-1:0]  gap;
    logic [abd_pkg::DUTY_W-1:0]  step;
    logic                        take;

    assign take      = head_valid & (~out_valid_reg | out_ready);
    assign pop       = take;
    assign out_valid = out_valid_reg;
    assign duty_out  = duty_out_reg;
    assign pwm_update  = pwm_update_reg;
    assign target_duty = target_out_reg;
    assign light_level = 3'(level_out_reg);

    // first match wins: day scans upward, night scans downward
    always_comb
    begin
        day_hit   = 1'b0;
        day_idx   = '0;
        night_hit = 1'b0;
        night_idx = '0;
        for (int i = abd_pkg::DAY_LEVELS - 1; i >= 0; i--)
        begin
            if (head.lux >= thresh_reg[i])
            begin
                day_hit = 1'b1;
                day_idx = abd_pkg::LEVEL_W'(i);
            end
        end
        for (int i = abd_pkg::DAY_LEVELS; i < abd_pkg::NUM_LEVELS; i++)
        begin
            if (head.lux <= thresh_reg[i])
            begin
                night_hit = 1'b1;
                night_idx = abd_pkg::LEVEL_W'(i);
            end
        end
    end

    always_comb
    begin
        level_next  = level_reg;
        target_next = target_reg;
        pick        = 1'b0;
        if (!head.welcome)
        begin
            target_next = abd_pkg::sat_duty(abd_pkg::LUX_W'(default_duty_reg));
        end
        else if (head.lux == invalid_lux_reg)
        begin
            level_next = abd_pkg::LEVEL_TOP;
            pick       = 1'b1;
        end
        else if (head.mode == abd_pkg::MODE_DAY && day_hit)
        begin
            level_next = day_idx;
            pick       = 1'b1;
        end
        else if (head.mode == abd_pkg::MODE_NIGHT && night_hit)
        begin
            level_next = night_idx;
            pick       = 1'b1;
        end

        case (head.choice)
            abd_pkg::CHOICE_AUTO: picked = auto_reg[level_next];
            abd_pkg::CHOICE_LOW:  picked = low_reg[level_next];
            abd_pkg::CHOICE_HIGH: picked = high_reg[level_next];
            default:              picked = med_reg[level_next];
        endcase
        if (pick)
        begin
            target_next = picked;
        end

        // slew toward target without overshoot
        slew = (slew_step_reg == '0) ? abd_pkg::DUTY_W'(1) : slew_step_reg;
        gap  = (target_next > duty_reg) ? target_next - duty_reg : duty_reg - target_next;
        step = (slew < gap) ? slew : gap;
        if (target_next > duty_reg)
        begin
            duty_next = duty_reg + step;
        end
        else
        begin
            duty_next = duty_reg - step;
        end
        pulse        = pending_reg | (target_next != duty_reg);
        pending_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duty_reg <= abd_pkg::DUTY_RESET;
            slew_step_reg    <= abd_pkg::SLEW_RESET;
            invalid_lux_reg  <= abd_pkg::INVALID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abd_pkg::CFG_DEFAULT_DUTY: default_duty_reg <= cfg_data[abd_pkg::DUTY_W-1:0];
                abd_pkg::CFG_SLEW_STEP:    slew_step_reg    <= cfg_data[abd_pkg::DUTY_W-1:0];
                abd_pkg::CFG_INVALID_LUX:  invalid_lux_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < abd_pkg::NUM_LEVELS; i++)
            begin
                thresh_reg[i] <= '0;
                low_reg[i]    <= '0;
                med_reg[i]    <= '0;
                high_reg[i]   <= '0;
                auto_reg[i]   <= '0;
            end
            target_reg  <= abd_pkg::DUTY_RESET;
            duty_reg    <= abd_pkg::DUTY_RESET;
            level_reg   <= '0;
            pending_reg <= 1'b1;
        end
        else if (take)
        begin
            case (head.kind)
                abd_pkg::KIND_WRITE:
                begin
                    case (head.col)
                        abd_pkg::COL_THRESH: thresh_reg[head.row] <= head.value;
                        abd_pkg::COL_LOW:  low_reg[head.row]  <= head.value[abd_pkg::DUTY_W-1:0];
                        abd_pkg::COL_MED:  med_reg[head.row]  <= head.value[abd_pkg::DUTY_W-1:0];
                        abd_pkg::COL_HIGH: high_reg[head.row] <= head.value[abd_pkg::DUTY_W-1:0];
                        abd_pkg::COL_AUTO: auto_reg[head.row] <= head.value[abd_pkg::DUTY_W-1:0];
                        default:           ;
                    endcase
                end
                abd_pkg::KIND_TICK:
                begin
                    target_reg  <= target_next;
                    duty_reg    <= duty_next;
                    level_reg   <= level_next;
                    pending_reg <= pending_next;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (head.kind == abd_pkg::KIND_TICK)
            begin
                duty_out_reg   <= duty_next;
                pwm_update_reg <= pulse;
                target_out_reg <= target_next;
                level_out_reg  <= level_next;
            end
            else
            begin
                duty_out_reg   <= duty_reg;
                pwm_update_reg <= 1'b0;
                target_out_reg <= target_reg;
                level_out_reg  <= level_reg;
            end
        end
    end

endmodule

// ===== rtl/ambient_backlight_dimmer_core.sv =====
// Ambient backlight dimmer top level: front end, two-entry queue, back end.
// Depends on abd_pkg, abd_front, abd_fifo, abd_back.
// Path: queue entry, then back-end execute from the queue head into the output
// register. Throughput: one item per cycle; output stalls fill the queue.
// Reset (rst_n low, asynchronous): queue and output empty, table zero, duty and
// target 50, level 0, update pending set, registers at defaults.
module ambient_backlight_dimmer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] lux,
    input  logic [1:0]  ambient_mode,
    input  logic [1:0]  brightness_choice,
    input  logic        ignition_on,
    input  logic        low_voltage_ok,
    input  logic        high_voltage_ok,
    input  logic        welcome_done,
    input  logic [2:0]  table_level,
    input  logic [2:0]  table_column,
    input  logic [15:0] table_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  duty_out,
    output logic        pwm_update,
    output logic [6:0]  target_duty,
    output logic [2:0]  light_level
);

    abd_pkg::item_t in_item;
    abd_pkg::item_t head;
    logic           head_valid;
    logic           pop;

    abd_front u_front (
        .opcode            (opcode),
        .lux               (lux),
        .ambient_mode      (ambient_mode),
        .brightness_choice (brightness_choice),
        .ignition_on       (ignition_on),
        .low_voltage_ok    (low_voltage_ok),
        .high_voltage_ok   (high_voltage_ok),
        .welcome_done      (welcome_done),
        .table_level       (table_level),
        .table_column      (table_column),
        .table_value       (table_value),
        .item              (in_item)
    );

    abd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (in_item),
        .not_full  (in_ready),
        .pop       (pop),
        .not_empty (head_valid),
        .head      (head)
    );

    abd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duty_out    (duty_out),
        .pwm_update  (pwm_update),
        .target_duty (target_duty),
        .light_level (light_level)
    );

endmodule

// ===== rtl/abd_checker.sv =====
// Port-level checks for the dimmer top level, bound onto it below.
// Depends only on the top level's ports.
module abd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [6:0] duty_out,
    input  logic [6:0] target_duty
);

    // a stalled result keeps its duty
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_out))
        else $error("result changed while stalled");

    // duty and target stay in percent range
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_out <= 7'd100 && target_duty <= 7'd100)
        else $error("duty out of range");

    // nothing is shown straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight after reset");

endmodule

bind ambient_backlight_dimmer_core abd_checker u_abd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .duty_out    (duty_out),
    .target_duty (target_duty)
);
